// ----- hdl/stp_pkg.sv -----
package stp_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SELF_TRADE = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam logic REG_CROSS_MODE = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  account_id;
    logic [47:0] client_ref;
    logic [31:0] instrument_id;
    logic [31:0] price_ticks;
    logic        is_limit;
    logic        is_buy;
    logic        is_immediate;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] opposite_ref;
  } rsp_t;

  typedef enum logic {OP_CHECK, OP_REMOVE} op_e;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SEL} state_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    req_t item;
  } queue_head_t;

  // isolate the lowest set bit
  function automatic logic [ORDER_SLOTS-1:0] lowest_one(input logic [ORDER_SLOTS-1:0] v);
    return v & (~v + {{(ORDER_SLOTS-1){1'b0}}, 1'b1});
  endfunction

endpackage

// ----- hdl/stp_front.sv -----
module stp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  stp_pkg::req_t       req,
  output stp_pkg::queue_head_t head,
  input  logic                pop
);
  import stp_pkg::*;

  typedef struct packed {
    op_e  op;
    req_t item;
  } entry_t;

  entry_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                do_pop;

  assign req_stall = (count == QCNT_W'(QDEPTH));
  assign push      = req_valid && !req_stall;
  assign do_pop    = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].op   <= req.cmd ? OP_REMOVE : OP_CHECK;
      entries[wr_ptr].item <= req;
    end
  end

  always_comb begin
    head.valid = (count != '0);
    head.op    = entries[rd_ptr].op;
    head.item  = entries[rd_ptr].item;
  end

endmodule

// ----- hdl/stp_table.sv -----
module stp_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cross_mode,
  input  stp_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output stp_pkg::rsp_t        rsp
);
  import stp_pkg::*;

  state_e state;
  state_e state_next;

  logic        slot_valid      [ORDER_SLOTS];
  logic [7:0]  slot_account    [ORDER_SLOTS];
  logic [47:0] slot_ref        [ORDER_SLOTS];
  logic [31:0] slot_instrument [ORDER_SLOTS];
  logic        slot_buy        [ORDER_SLOTS];
  logic [31:0] slot_price      [ORDER_SLOTS];

  op_e  cur_op;
  req_t cur;

  logic [ORDER_SLOTS-1:0] hit_cmp, own_cmp, free_cmp;
  logic [ORDER_SLOTS-1:0] hit_vec, own_vec, free_vec;
  logic [ORDER_SLOTS-1:0] hit_oh, own_oh, free_oh;

  logic        out_free;
  logic        take;
  logic        commit;
  logic        cmp_en;
  logic        do_insert;
  logic        do_remove;
  logic [1:0]  res_status;
  logic [47:0] res_opp;
  logic [47:0] hit_ref;

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (head.valid) state_next = S_CMP;
      S_CMP:  state_next = S_SEL;
      S_SEL: begin
        if (out_free) state_next = head.valid ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    take   = 1'b0;
    commit = 1'b0;
    cmp_en = 1'b0;
    unique case (state)
      S_IDLE: take = head.valid;
      S_CMP:  cmp_en = 1'b1;
      S_SEL: begin
        commit = out_free;
        take   = out_free && head.valid;
      end
      default: ;
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_op <= head.op;
      cur    <= head.item;
    end
  end

  // per-slot compare, all slots side by side
  always_comb begin
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      hit_cmp[i] = slot_valid[i]
                && (cross_mode || slot_account[i] == cur.account_id)
                && slot_instrument[i] == cur.instrument_id
                && slot_buy[i] != cur.is_buy
                && (!cur.is_limit
                    || (cur.is_buy && cur.price_ticks >= slot_price[i])
                    || (!cur.is_buy && cur.price_ticks <= slot_price[i]));
      own_cmp[i]  = slot_valid[i] && slot_account[i] == cur.account_id
                 && slot_ref[i] == cur.client_ref;
      free_cmp[i] = !slot_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_vec  <= hit_cmp;
      own_vec  <= own_cmp;
      free_vec <= free_cmp;
    end
  end

  assign hit_oh  = lowest_one(hit_vec);
  assign own_oh  = lowest_one(own_vec);
  assign free_oh = lowest_one(free_vec);

  always_comb begin
    hit_ref = '0;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      hit_ref = hit_ref | (hit_oh[i] ? slot_ref[i] : 48'd0);
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_opp    = '0;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    priority if (cur_op == OP_REMOVE) begin
      do_remove = commit;
    end else if (hit_vec != '0) begin
      res_status = ST_SELF_TRADE;
      res_opp    = hit_ref;
    end else if (!cur.is_immediate && own_vec == '0) begin
      if (free_vec == '0) res_status = ST_FULL;
      else                do_insert  = commit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER_SLOTS; i++) slot_valid[i] <= 1'b0;
    end else begin
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (do_remove && own_oh[i])  slot_valid[i] <= 1'b0;
        if (do_insert && free_oh[i]) slot_valid[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (do_insert && free_oh[i]) begin
        slot_account[i]    <= cur.account_id;
        slot_ref[i]        <= cur.client_ref;
        slot_instrument[i] <= cur.instrument_id;
        slot_buy[i]        <= cur.is_buy;
        slot_price[i]      <= cur.price_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               rsp_valid <= 1'b0;
    else if (commit)       rsp_valid <= 1'b1;
    else if (!rsp_stall)   rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status       <= res_status;
      rsp.opposite_ref <= res_opp;
    end
  end

endmodule

// ----- hdl/self_trade_prevention_check.sv -----
// Self-trade prevention check. Each request either checks a new order against
// a table of ORDER_SLOTS resting orders (inserting it into the lowest free slot
// when it does not trade against itself, is not immediate and does not repeat
// a resting reference of its account) or removes a terminated order; each
// request gives exactly one response. A two-entry request queue feeds the table
// engine, one request at a time: the compare state registers the match against
// every slot at once; the select state picks the lowest-index match, writes the
// table and loads the response register, waiting while a held response stalls.
// Valid marks are flip-flops cleared at reset, so there is no clearing pass.
// cross_account_mode (address 0) should only be written while idle.
module self_trade_prevention_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  stp_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output stp_pkg::rsp_t  rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [0:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import stp_pkg::*;

  logic        cross_mode;
  queue_head_t head;
  logic        pop;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_CROSS_MODE) begin
      cross_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr == REG_CROSS_MODE) ? {31'd0, cross_mode} : 32'd0;

  // front: queue and classify
  stp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .pop       (pop)
  );

  // back: table compare and update
  stp_table u_table (
    .clk        (clk),
    .rst        (rst),
    .cross_mode (cross_mode),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

  // opposite ref only accompanies a self-trade
  a_opp_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_SELF_TRADE |-> rsp.opposite_ref == 48'd0)
    else $error("opposite_ref set without self-trade");

  // an accepted request lands in the queue
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> head.valid)
    else $error("accepted request missing from queue");

  // engine never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import stp_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  self_trade_prevention_check dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the order table, updated as each request is accepted.
  logic        book_valid [ORDER_SLOTS];
  logic [7:0]  book_acct  [ORDER_SLOTS];
  logic [47:0] book_ref   [ORDER_SLOTS];
  logic [31:0] book_instr [ORDER_SLOTS];
  logic        book_buy   [ORDER_SLOTS];
  logic [31:0] book_price [ORDER_SLOTS];
  logic        cross_mode;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   error_count;
  int   accepted_count;

  // Idle control: bursts on both sides, switched off near the end.
  bit   quiet;
  int   send_gap;
  int   recv_gap;
  int   hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("self_trade_prevention_check test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int find_order(input logic [7:0] acct, input logic [47:0] oref);
    for (int i = 0; i < ORDER_SLOTS; i++)
      if (book_valid[i] && book_acct[i] == acct && book_ref[i] == oref) return i;
    return -1;
  endfunction

  // Predict the response of one request and update the shadow table.
  function automatic rsp_t screen_order(input req_t r);
    rsp_t o;
    int   k;
    int   slot;
    bit   hit;
    o.status = ST_OK;
    o.opposite_ref = '0;
    hit = 0;
    if (op_e'(r.cmd) == OP_REMOVE) begin
      k = find_order(r.account_id, r.client_ref);
      if (k >= 0) book_valid[k] = 1'b0;
      return o;
    end
    for (int i = 0; i < ORDER_SLOTS && !hit; i++) begin
      if (book_valid[i] && (cross_mode || book_acct[i] == r.account_id) &&
          book_instr[i] == r.instrument_id && book_buy[i] != r.is_buy &&
          (!r.is_limit || (r.is_buy && r.price_ticks >= book_price[i]) ||
           (!r.is_buy && r.price_ticks <= book_price[i]))) begin
        hit = 1;
        o.status = ST_SELF_TRADE;
        o.opposite_ref = book_ref[i];
      end
    end
    if (!hit && !r.is_immediate && find_order(r.account_id, r.client_ref) < 0) begin
      slot = -1;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--)
        if (!book_valid[i]) slot = i;
      if (slot < 0) begin
        o.status = ST_FULL;
      end else begin
        book_valid[slot] = 1'b1;
        book_acct[slot]  = r.account_id;
        book_ref[slot]   = r.client_ref;
        book_instr[slot] = r.instrument_id;
        book_buy[slot]   = r.is_buy;
        book_price[slot] = r.price_ticks;
      end
    end
    return o;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        expected_rsps.push_back(screen_order(req));
        accepted_count++;
      end
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted down on its own.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Response monitor and stall generator.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with none expected");
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status)
            report_mismatch($sformatf("status %0d expected %0d", rsp.status, e.status));
          if (rsp.opposite_ref !== e.opposite_ref)
            report_mismatch($sformatf("opposite_ref %h expected %h",
                                      rsp.opposite_ref, e.opposite_ref));
        end
      end
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 10);
      end
    end
  end

  task automatic write_cross_mode(input logic v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_CROSS_MODE;
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cross_mode = v;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t make_order(input logic [7:0] acct, input logic [47:0] oref,
                                      input logic [31:0] instr, input logic [31:0] px,
                                      input bit lim, input bit buy, input bit imm);
    req_t r;
    r.cmd = OP_CHECK;
    r.account_id = acct;
    r.client_ref = oref;
    r.instrument_id = instr;
    r.price_ticks = px;
    r.is_limit = lim;
    r.is_buy = buy;
    r.is_immediate = imm;
    return r;
  endfunction

  // Mostly small pools of accounts, references and instruments so that
  // matches, duplicates and removes of live orders occur often.
  function automatic req_t random_req();
    req_t r;
    r.cmd = ($urandom_range(0, 99) < 35) ? OP_REMOVE : OP_CHECK;
    r.account_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.client_ref = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                               : 48'($urandom_range(0, 40));
    r.instrument_id = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                  : 32'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: r.price_ticks = 32'($urandom);
      1: r.price_ticks = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'd0;
      default: r.price_ticks = 32'd1000 + 32'($urandom_range(0, 6));
    endcase
    r.is_limit = ($urandom_range(0, 4) != 0);
    r.is_buy = 1'($urandom_range(0, 1));
    r.is_immediate = ($urandom_range(0, 5) == 0);
    return r;
  endfunction

  initial begin
    req_t r;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    error_count = 0;
    accepted_count = 0;
    quiet = 0;
    hold_cycles = 0;
    cross_mode = 1'b0;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      book_valid[i] = 1'b0;
      book_acct[i] = '0;
      book_ref[i] = '0;
      book_instr[i] = '0;
      book_buy[i] = 1'b0;
      book_price[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_cross_mode(1'b0);
    // Directed: resting sell, buys below, at and above, market order,
    // immediate, duplicate reference, other account, removes.
    pending_reqs.push_back(make_order(8'd1, 48'd10, 32'd5, 32'd100, 1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_order(8'd1, 48'd11, 32'd5, 32'd99, 1'b1, 1'b1, 1'b0));
    pending_reqs.push_back(make_order(8'd1, 48'd12, 32'd5, 32'd100, 1'b1, 1'b1, 1'b1));
    pending_reqs.push_back(make_order(8'd1, 48'd13, 32'd5, 32'd0, 1'b0, 1'b1, 1'b0));
    pending_reqs.push_back(make_order(8'd1, 48'd11, 32'd5, 32'd50, 1'b1, 1'b1, 1'b0));
    pending_reqs.push_back(make_order(8'd1, 48'd20, 32'd5, 32'd98, 1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_order(8'd2, 48'd30, 32'd5, 32'hFFFF_FFFF,
                                      1'b1, 1'b1, 1'b0));
    pending_reqs.push_back(make_order(8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_order(8'd3, 48'd40, 32'd6, 32'd7, 1'b1, 1'b0, 1'b1));
    r = make_order(8'd1, 48'd10, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    r.cmd = OP_REMOVE;
    pending_reqs.push_back(r);
    r.client_ref = 48'd999;
    pending_reqs.push_back(r);
    wait_drained();

    write_cross_mode(1'b1);
    pending_reqs.push_back(make_order(8'd9, 48'd50, 32'd5, 32'd0, 1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_order(8'd0, 48'd51, 32'hFFFF_FFFF, 32'd0,
                                      1'b1, 1'b1, 1'b0));
    // Fill the table to reach the full status, including a full-table immediate.
    for (int i = 0; i < ORDER_SLOTS + 2; i++)
      pending_reqs.push_back(make_order(8'd7, 48'(100 + i), 32'(1000 + i), 32'd5,
                                        1'b1, 1'b1, 1'b0));
    pending_reqs.push_back(make_order(8'd7, 48'd500, 32'd77, 32'd5, 1'b1, 1'b1, 1'b1));
    wait_drained();
    for (int i = 0; i < ORDER_SLOTS + 2; i++) begin
      r = make_order(8'd7, 48'(100 + i), 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
      r.cmd = OP_REMOVE;
      pending_reqs.push_back(r);
    end
    // Long receiver hold while requests keep coming, so the input backs up.
    hold_cycles = 200;
    wait_drained();

    // Random phases, alternating the cross-account setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_cross_mode(ph[0]);
      if (ph == 5) quiet = 1;
      for (int i = 0; i < 150; i++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("self_trade_prevention_check test passed");
    end else begin
      $display("self_trade_prevention_check test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/stp_pkg.sv
hdl/stp_front.sv
hdl/stp_table.sv
hdl/self_trade_prevention_check.sv
bench/tb.sv
